FILE: rtl/erg_pkg.sv
// ---------------------------------------------------------------------------
// Encoder rotation tap generator package
// Shared widths, codes, interface structs and the step count clamp.
// ---------------------------------------------------------------------------
package erg_pkg;

    // Layer store
    localparam int LAYERS  = 8;
    localparam int LAYER_W = 3;

    // Tap run limits
    localparam int MAX_TAPS = 32;
    localparam int TAP_W    = $clog2(MAX_TAPS + 1);
    localparam int PEND_W   = TAP_W + 1;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int WHOLE_W  = 10;
    localparam int MICRO_W  = 21;
    localparam int TPR_W    = 9;
    localparam int HOLD_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_TPR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 1'd1;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_ACCEPT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TRIGGER = 2'd1;

    // Shared divider widths
    localparam int DVD_W  = 22;
    localparam int DVR_W  = 20;
    localparam int ITER_W = 5;

    // Arithmetic constants
    localparam logic [DVR_W-1:0] MICRO_PER_DEG = 20'd1000000;
    localparam logic [TPR_W-1:0] FULL_TURN     = 9'd360;

    // Divider command and response
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVR_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVR_W-1:0] remainder;
    } div_rsp_t;

    // Tap run command
    typedef struct packed {
        logic              start;
        logic              clockwise;
        logic [TAP_W-1:0]  count;
        logic [HOLD_W-1:0] hold;
    } tap_req_t;

    // Saturate a signed step count to plus or minus MAX_TAPS.
    function automatic logic signed [PEND_W-1:0] clamp_taps(input logic signed [DVD_W-1:0] n);
        logic signed [DVD_W-1:0] hi;
        logic signed [DVD_W-1:0] lo;
        hi = $signed(DVD_W'(MAX_TAPS));
        lo = -hi;
        if (n > hi)
        begin
            return PEND_W'(hi);
        end
        else if (n < lo)
        begin
            return PEND_W'(lo);
        end
        return PEND_W'(n);
    endfunction

endpackage

FILE: rtl/erg_divider.sv
// ---------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the given number of iterations is run.
// ---------------------------------------------------------------------------
module erg_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  erg_pkg::div_req_t req,
    output erg_pkg::div_rsp_t rsp
);
    import erg_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DVR_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVR_W-1:0]  dvsr_reg;

    logic [DVR_W:0]    shifted;
    logic [DVR_W:0]    diff;
    logic              fits;
    logic [DVR_W-1:0]  rem_next;

    // One trial subtraction per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = shifted - {1'b0, dvsr_reg};
        fits     = !diff[DVR_W];
        rem_next = fits ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start && !busy_reg)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.iters;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/erg_tap_emitter.sv
// ---------------------------------------------------------------------------
// Tap run emitter
// Plays out press and release beats for a run of steps through a
// registered output stage.
// ---------------------------------------------------------------------------
module erg_tap_emitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  erg_pkg::tap_req_t            req,
    output logic                         busy,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         clockwise,
    output logic                         press,
    output logic [erg_pkg::HOLD_W-1:0]   hold_ms,
    output logic                         last
);
    import erg_pkg::*;

    logic              busy_reg;
    logic              cw_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [TAP_W-1:0]  left_reg;
    logic              release_reg;

    logic              out_valid_reg;
    logic              out_cw_reg;
    logic              out_press_reg;
    logic [HOLD_W-1:0] out_hold_reg;
    logic              out_last_reg;

    logic              load;

    // During a run, a beat is loaded whenever the output stage is empty or being taken
    assign load = busy_reg && (!out_valid_reg || !out_stall);

    // Run control and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            release_reg   <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.start && !busy_reg)
            begin
                busy_reg    <= 1'b1;
                release_reg <= 1'b0;
                left_reg    <= req.count;
            end
            else if (load)
            begin
                release_reg <= !release_reg;
                if (release_reg)
                begin
                    left_reg <= left_reg - 1'b1;
                    if (left_reg == TAP_W'(1))
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Run payload and output beat contents
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            cw_reg   <= req.clockwise;
            hold_reg <= req.hold;
        end
        if (load)
        begin
            out_cw_reg    <= cw_reg;
            out_press_reg <= !release_reg;
            out_hold_reg  <= release_reg ? '0 : hold_reg;
            out_last_reg  <= release_reg && (left_reg == TAP_W'(1));
        end
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign clockwise = out_cw_reg;
    assign press     = out_press_reg;
    assign hold_ms   = out_hold_reg;
    assign last      = out_last_reg;

endmodule

FILE: rtl/encoder_rotation_tap_generator.sv
// ---------------------------------------------------------------------------
// Encoder rotation tap generator
// Turns per-layer rotation reports into runs of press and release taps.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one request per beat:
// rotation data, a trigger or a clear for one layer. The output channel
// (out_valid / out_stall) carries one tap event per beat. Registers must be
// written through cfg_we / cfg_index / cfg_data while the block is idle; the
// block itself does not enforce this. Rotation data with non-zero whole
// degrees first folds the millionths into whole degrees by compare and
// subtract (one step per cycle, at most two), then runs two divisions on one
// shared restoring divider (9 and 10 iterations, one bit per cycle). Raw step
// data and clears finish in the decode state. A trigger with n pending steps
// produces 2n beats, one per cycle when the receiver does not stall; the
// input stays stalled until the last beat has entered the output register.
// A stall on the output simply holds the current beat and pauses the run.
// Reset clears all layer remainders and pending counts and restores 20 steps
// per rotation and a 5 ms hold.
// ---------------------------------------------------------------------------
module encoder_rotation_tap_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [erg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [erg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [erg_pkg::ACT_W-1:0]           action,
    input  logic [erg_pkg::LAYER_W-1:0]         layer,
    input  logic signed [erg_pkg::WHOLE_W-1:0]  whole_degrees,
    input  logic signed [erg_pkg::MICRO_W-1:0]  micro_degrees,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                clockwise,
    output logic                                press,
    output logic [erg_pkg::HOLD_W-1:0]          hold_ms,
    output logic                                last
);
    import erg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_MICRO  = 6'b000100,
        ST_STEP   = 6'b001000,
        ST_QUOT   = 6'b010000,
        ST_TAPS   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [TPR_W-1:0]  tpr_reg;
    logic [HOLD_W-1:0] hold_reg;

    // Captured request
    logic [ACT_W-1:0]          act_reg;
    logic [LAYER_W-1:0]        layer_reg;
    logic signed [WHOLE_W-1:0] whole_reg;
    logic signed [MICRO_W-1:0] micro_reg;

    // Working values
    logic signed [11:0] rw_reg;
    logic signed [11:0] rw_next;
    logic               rm_neg_reg;
    logic [MICRO_W-1:0] rm_mag_reg;
    logic               rm_carry;

    // Per-layer state
    logic signed [WHOLE_W-1:0] rem_whole_reg [LAYERS];
    logic signed [MICRO_W-1:0] rem_micro_reg [LAYERS];
    logic signed [PEND_W-1:0]  pend_reg      [LAYERS];

    div_req_t div_req;
    div_rsp_t div_rsp;
    tap_req_t tap_req;
    logic     tap_busy;

    logic                      in_accept;
    logic                      layer_ok;
    logic signed [WHOLE_W-1:0] cur_rw;
    logic signed [MICRO_W-1:0] cur_rm;
    logic signed [PEND_W-1:0]  cur_pend;
    logic signed [DVD_W-1:0]   rm_sum;
    logic [DVD_W-1:0]          rm_mag;
    logic signed [11:0]        rw_base;
    logic [11:0]               rw_mag;
    logic [TPR_W-1:0]          tpr_eff;
    logic signed [MICRO_W-1:0] rm_new;
    logic [10:0]               q_step;
    logic signed [WHOLE_W-1:0] rw_new;
    logic signed [PEND_W-1:0]  pend_raw;
    logic signed [PEND_W-1:0]  pend_div;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpr_reg  <= TPR_W'(20);
            hold_reg <= HOLD_W'(5);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TPR)
            begin
                tpr_reg <= cfg_data[TPR_W-1:0];
            end
            else if (cfg_index == CFG_HOLD)
            begin
                hold_reg <= cfg_data[HOLD_W-1:0];
            end
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg   <= action;
            layer_reg <= layer;
            whole_reg <= whole_degrees;
            micro_reg <= micro_degrees;
        end
    end

    // Layer state read and the arithmetic around the divider
    always_comb
    begin
        layer_ok = ({1'b0, layer_reg} < (LAYER_W + 1)'(LAYERS));
        cur_rw   = rem_whole_reg[layer_reg];
        cur_rm   = rem_micro_reg[layer_reg];
        cur_pend = pend_reg[layer_reg];

        rm_sum  = {cur_rm[MICRO_W-1], cur_rm} + {micro_reg[MICRO_W-1], micro_reg};
        rm_mag  = rm_sum[DVD_W-1] ? DVD_W'(-rm_sum) : DVD_W'(rm_sum);
        rw_base = {{2{cur_rw[WHOLE_W-1]}}, cur_rw} + {{2{whole_reg[WHOLE_W-1]}}, whole_reg};
        rw_mag  = rw_reg[11] ? 12'(-rw_reg) : 12'(rw_reg);

        // Out-of-range step counts fold to the nearest valid value
        if (tpr_reg == '0)
        begin
            tpr_eff = TPR_W'(1);
        end
        else if (tpr_reg > FULL_TURN)
        begin
            tpr_eff = FULL_TURN;
        end
        else
        begin
            tpr_eff = tpr_reg;
        end

        // Truncating fold: each whole degree taken from the millionths moves
        // the whole part one step in the direction of the millionths' sign
        rm_carry = (rm_mag_reg >= {1'b0, MICRO_PER_DEG});
        rw_next  = rm_neg_reg ? rw_reg - 12'sd1 : rw_reg + 12'sd1;
        rm_new   = rm_neg_reg ? -$signed({1'b0, rm_mag_reg[MICRO_W-2:0]})
                              : $signed({1'b0, rm_mag_reg[MICRO_W-2:0]});

        q_step   = {1'b0, div_rsp.quotient[9:0]};
        rw_new   = rw_reg[11] ? -$signed({1'b0, div_rsp.remainder[8:0]})
                              : $signed({1'b0, div_rsp.remainder[8:0]});
        pend_div = clamp_taps(rw_reg[11] ? -$signed({11'b0, q_step})
                                         : $signed({11'b0, q_step}));
        pend_raw = clamp_taps({micro_reg[MICRO_W-1], micro_reg});
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.iters    = '0;
        tap_req.start     = 1'b0;
        tap_req.clockwise = !cur_pend[PEND_W-1];
        tap_req.count     = cur_pend[PEND_W-1] ? TAP_W'(-cur_pend) : TAP_W'(cur_pend);
        tap_req.hold      = hold_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                if (layer_ok && act_reg == ACT_ACCEPT && whole_reg != '0)
                begin
                    // Fold millionths into whole degrees
                    state_next = ST_MICRO;
                end
                else if (layer_ok && act_reg == ACT_TRIGGER && cur_pend != '0)
                begin
                    tap_req.start = 1'b1;
                    state_next    = ST_TAPS;
                end
            end
            ST_MICRO:
            begin
                if (!rm_carry)
                begin
                    // Degrees per step
                    div_req.start    = 1'b1;
                    div_req.dividend = {FULL_TURN, 13'b0};
                    div_req.divisor  = DVR_W'(tpr_eff);
                    div_req.iters    = ITER_W'(9);
                    state_next       = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (div_rsp.done)
                begin
                    // Whole degrees into steps
                    div_req.start    = 1'b1;
                    div_req.dividend = {rw_mag[9:0], 12'b0};
                    div_req.divisor  = DVR_W'(div_rsp.quotient[TPR_W-1:0]);
                    div_req.iters    = ITER_W'(10);
                    state_next       = ST_QUOT;
                end
            end
            ST_QUOT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TAPS:
            begin
                if (!tap_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECODE)
        begin
            rw_reg     <= rw_base;
            rm_neg_reg <= rm_sum[DVD_W-1];
            rm_mag_reg <= rm_mag[MICRO_W-1:0];
        end
        else if (state_reg == ST_MICRO && rm_carry)
        begin
            rw_reg     <= rw_next;
            rm_mag_reg <= rm_mag_reg - {1'b0, MICRO_PER_DEG};
        end
    end

    // Per-layer remainder and pending count updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAYERS; i++)
            begin
                rem_whole_reg[i] <= '0;
                rem_micro_reg[i] <= '0;
                pend_reg[i]      <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_DECODE && layer_ok)
            begin
                if (act_reg == ACT_ACCEPT)
                begin
                    if (whole_reg == '0)
                    begin
                        pend_reg[layer_reg] <= pend_raw;
                    end
                end
                else if (act_reg != ACT_TRIGGER)
                begin
                    pend_reg[layer_reg] <= '0;
                end
            end
            if (state_reg == ST_MICRO && !rm_carry)
            begin
                rem_micro_reg[layer_reg] <= rm_new;
            end
            if (state_reg == ST_QUOT && div_rsp.done)
            begin
                rem_whole_reg[layer_reg] <= rw_new;
                pend_reg[layer_reg]      <= pend_div;
            end
        end
    end

    // Shared divider
    erg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Tap run output
    erg_tap_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (tap_req),
        .busy      (tap_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .clockwise (clockwise),
        .press     (press),
        .hold_ms   (hold_ms),
        .last      (last)
    );

endmodule

FILE: test/encoder_rotation_tap_generator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Encoder rotation tap generator testbench
// Sends rotation, trigger and clear requests while both channels idle and
// stall at random. Every tap beat is compared with the output of a
// per-layer prediction of remainders and pending step counts.
// ---------------------------------------------------------------------------
module encoder_rotation_tap_generator_tb;
    import erg_pkg::*;

    // Request codes that the package leaves unnamed
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int MICRO_PER_DEGREE = 1000000;
    localparam int DEGREES_PER_TURN = 360;
    localparam int SETTLE_CYCLES    = 60;
    localparam int DRAIN_LIMIT      = 200000;

    typedef struct packed {
        logic              clockwise;
        logic              press;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } tap_beat_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index     = '0;
    logic [CFG_DATA_W-1:0]     cfg_data      = '0;
    logic                      in_valid      = 1'b0;
    logic                      in_stall;
    logic [ACT_W-1:0]          action        = ACT_ACCEPT;
    logic [LAYER_W-1:0]        layer         = '0;
    logic signed [WHOLE_W-1:0] whole_degrees = '0;
    logic signed [MICRO_W-1:0] micro_degrees = '0;
    logic                      out_valid;
    logic                      out_stall     = 1'b0;
    logic                      clockwise;
    logic                      press;
    logic [HOLD_W-1:0]         hold_ms;
    logic                      last;

    // Predicted block state
    int tpr_setting  = 20;
    int hold_setting = 5;
    int rem_whole [LAYERS] = '{default: 0};
    int rem_micro [LAYERS] = '{default: 0};
    int steps_pending [LAYERS] = '{default: 0};
    tap_beat_t expected_taps[$];

    int errors          = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_off_len    = 0;
    int hold_off_id     = 0;
    int hold_off_seen   = 0;
    int hold_off_left   = 0;

    encoder_rotation_tap_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .layer         (layer),
        .whole_degrees (whole_degrees),
        .micro_degrees (micro_degrees),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .clockwise     (clockwise),
        .press         (press),
        .hold_ms       (hold_ms),
        .last          (last)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run time limit.
    initial
    begin
        #2000000;
        $display("encoder_rotation_tap_generator: mismatch");
        $finish;
    end

    // Receiver stall: a requested hold-off takes priority over random stalls.
    always @(posedge clk)
    begin
        if (hold_off_id != hold_off_seen)
        begin
            hold_off_seen = hold_off_id;
            hold_off_left = hold_off_len;
        end
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted tap beat with the oldest expected one.
    always @(posedge clk)
    begin : check_taps
        tap_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_taps.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual cw=%0b press=%0b hold=%0d last=%0b",
                         $time, clockwise, press, hold_ms, last);
            end
            else
            begin
                want = expected_taps.pop_front();
                if (want.clockwise !== clockwise)
                begin
                    errors++;
                    $display("%0t: clockwise: expected %0b, actual %0b",
                             $time, want.clockwise, clockwise);
                end
                if (want.press !== press)
                begin
                    errors++;
                    $display("%0t: press: expected %0b, actual %0b", $time, want.press, press);
                end
                if (want.hold !== hold_ms)
                begin
                    errors++;
                    $display("%0t: hold_ms: expected %0d, actual %0d", $time, want.hold, hold_ms);
                end
                if (want.last !== last)
                begin
                    errors++;
                    $display("%0t: last: expected %0b, actual %0b", $time, want.last, last);
                end
            end
        end
    end

    // Saturate a step count to the tap run limit.
    function automatic int clamp_steps(input int n);
        if (n > MAX_TAPS)
        begin
            return MAX_TAPS;
        end
        if (n < -MAX_TAPS)
        begin
            return -MAX_TAPS;
        end
        return n;
    endfunction

    // Update the layer state for one accepted request and queue its tap beats.
    task automatic predict_taps(input logic [ACT_W-1:0] act, input logic [LAYER_W-1:0] lyr,
                                input logic signed [WHOLE_W-1:0] whole,
                                input logic signed [MICRO_W-1:0] micro);
        int w;
        int m;
        int tpr;
        int step_deg;
        int rw;
        int rm;
        int n;
        int i;
        logic cw;
        tap_beat_t beat;
        w = whole;
        m = micro;
        if (lyr >= LAYERS)
        begin
            return;
        end
        if (act == ACT_ACCEPT)
        begin
            if (w == 0)
            begin
                // Raw step mode loads the count directly.
                steps_pending[lyr] = clamp_steps(m);
            end
            else
            begin
                tpr = tpr_setting;
                if (tpr == 0)
                begin
                    tpr = 1;
                end
                if (tpr > DEGREES_PER_TURN)
                begin
                    tpr = DEGREES_PER_TURN;
                end
                step_deg = DEGREES_PER_TURN / tpr;
                rw = rem_whole[lyr] + w;
                rm = rem_micro[lyr] + m;
                rw = rw + rm / MICRO_PER_DEGREE;
                rm = rm % MICRO_PER_DEGREE;
                n  = rw / step_deg;
                rw = rw % step_deg;
                rem_whole[lyr] = rw;
                rem_micro[lyr] = rm;
                steps_pending[lyr] = clamp_steps(n);
            end
        end
        else if (act != ACT_TRIGGER)
        begin
            steps_pending[lyr] = 0;
        end
        else
        begin
            // A trigger leaves the count in place and emits press/release pairs.
            n  = steps_pending[lyr];
            cw = (n > 0);
            if (n < 0)
            begin
                n = -n;
            end
            for (i = 0; i < n; i++)
            begin
                beat.clockwise = cw;
                beat.press     = 1'b1;
                beat.hold      = hold_setting[HOLD_W-1:0];
                beat.last      = 1'b0;
                expected_taps.push_back(beat);
                beat.press     = 1'b0;
                beat.hold      = '0;
                beat.last      = (i == n - 1);
                expected_taps.push_back(beat);
            end
        end
    endtask

    // Offer one request beat, with a random idle gap ahead of it.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [LAYER_W-1:0] lyr,
                                input logic signed [WHOLE_W-1:0] whole,
                                input logic signed [MICRO_W-1:0] micro);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        in_valid      <= 1'b1;
        action        <= act;
        layer         <= lyr;
        whole_degrees <= whole;
        micro_degrees <= micro;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_taps(act, lyr, whole, micro);
    endtask

    // Let every expected beat arrive and the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_taps.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register once the block is idle.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TPR)
        begin
            tpr_setting = value[TPR_W-1:0];
        end
        else
        begin
            hold_setting = value;
        end
    endtask

    // Whole degrees: mostly within a turn, sometimes any bit pattern.
    function automatic logic signed [WHOLE_W-1:0] random_whole();
        if ($urandom_range(0, 99) < 85)
        begin
            return WHOLE_W'($urandom_range(0, 720) - 360);
        end
        return WHOLE_W'($urandom());
    endfunction

    // Millionths: mostly within one degree, sometimes any bit pattern.
    function automatic logic signed [MICRO_W-1:0] random_micro();
        if ($urandom_range(0, 99) < 85)
        begin
            return MICRO_W'($urandom_range(0, 1999998) - 999999);
        end
        return MICRO_W'($urandom());
    endfunction

    // Rotation data for one layer, in raw step mode about a quarter of the time.
    task automatic send_random_rotation(input logic [LAYER_W-1:0] lyr);
        logic signed [MICRO_W-1:0] steps;
        if ($urandom_range(0, 99) < 25)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                steps = MICRO_W'($urandom_range(0, 80) - 40);
            end
            else
            begin
                steps = MICRO_W'($urandom());
            end
            send_request(ACT_ACCEPT, lyr, '0, steps);
        end
        else
        begin
            send_request(ACT_ACCEPT, lyr, random_whole(), random_micro());
        end
    endtask

    // Corner requests under the reset settings of 18 degrees per step.
    task automatic test_directed_cases();
        send_request(ACT_ACCEPT, 3'd0, 10'sd0, 21'sd5);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        // A second trigger repeats the run since the count is kept.
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_CLEAR, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_ACCEPT, 3'd1, 10'sd0, -21'sd3);
        send_request(ACT_TRIGGER, 3'd1, 10'sd0, 21'sd0);
        // Raw counts at both field extremes saturate.
        send_request(ACT_ACCEPT, 3'd2, 10'sd0, 21'sh0FFFFF);
        send_request(ACT_TRIGGER, 3'd2, 10'sd0, 21'sd0);
        send_request(ACT_ACCEPT, 3'd3, 10'sd0, 21'sh100000);
        send_request(ACT_TRIGGER, 3'd3, 10'sd0, 21'sd0);
        // Rotation at both field extremes.
        send_request(ACT_ACCEPT, 3'd4, 10'sh1FF, 21'sh0FFFFF);
        send_request(ACT_TRIGGER, 3'd4, 10'sd0, 21'sd0);
        send_request(ACT_ACCEPT, 3'd5, 10'sh200, 21'sh100000);
        send_request(ACT_TRIGGER, 3'd5, 10'sd0, 21'sd0);
        // Millionths carry into whole degrees across two reports.
        send_request(ACT_ACCEPT, 3'd6, 10'sd17, 21'sd999999);
        send_request(ACT_ACCEPT, 3'd6, 10'sd1, 21'sd1);
        send_request(ACT_TRIGGER, 3'd6, 10'sd0, 21'sd0);
        // Opposite signs in the two parts.
        send_request(ACT_ACCEPT, 3'd7, -10'sd1, 21'sd500000);
        send_request(ACT_ACCEPT, 3'd7, -10'sd40, -21'sd700000);
        send_request(ACT_TRIGGER, 3'd7, 10'sd0, 21'sd0);
        // The unused code clears like any other non-trigger, non-rotation request.
        send_request(ACT_SPARE, 3'd7, 10'sd0, 21'sd0);
        send_request(ACT_TRIGGER, 3'd7, 10'sd0, 21'sd0);
        send_request(ACT_ACCEPT, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
    endtask

    // Step size and hold time at their extremes, out-of-range step counts too.
    task automatic test_register_extremes();
        int tpr_list [5]  = '{0, 511, 360, 1, 7};
        int hold_list [5] = '{65535, 0, 1, 32768, 5};
        int k;
        logic [LAYER_W-1:0] lyr;
        for (k = 0; k < 5; k++)
        begin
            write_register(CFG_TPR, CFG_DATA_W'(tpr_list[k]));
            write_register(CFG_HOLD, CFG_DATA_W'(hold_list[k]));
            lyr = LAYER_W'($urandom_range(0, LAYERS - 1));
            send_request(ACT_ACCEPT, lyr, random_whole(), random_micro());
            send_request(ACT_TRIGGER, lyr, 10'sd0, 21'sd0);
        end
    endtask

    // Mostly rotation reports followed by a trigger, the rest any request at all.
    task automatic random_phase(input int idle_pct, input int stall_pct, input int items);
        int sent;
        int reports;
        int k;
        logic [LAYER_W-1:0] lyr;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            lyr = LAYER_W'($urandom_range(0, LAYERS - 1));
            if ($urandom_range(0, 99) < 70)
            begin
                reports = $urandom_range(1, 3);
                for (k = 0; k < reports; k++)
                begin
                    send_random_rotation(lyr);
                end
                send_request(ACT_TRIGGER, lyr, 10'sd0, 21'sd0);
                sent += reports + 1;
            end
            else
            begin
                send_request(ACT_W'($urandom_range(0, 3)), lyr,
                             WHOLE_W'($urandom()), MICRO_W'($urandom()));
                sent++;
            end
        end
    endtask

    // Random traffic in four phases, each with its own settings and idle and stall rates.
    task automatic test_random_traffic();
        write_register(CFG_TPR, 16'hA000 | 16'd36);
        write_register(CFG_HOLD, 16'd1234);
        random_phase(0, 0, 30);
        write_register(CFG_TPR, 16'd360);
        write_register(CFG_HOLD, 16'd7);
        random_phase(66, 0, 30);
        write_register(CFG_TPR, 16'd3);
        write_register(CFG_HOLD, 16'd40000);
        random_phase(0, 66, 30);
        write_register(CFG_TPR, CFG_DATA_W'($urandom_range(1, 360)));
        write_register(CFG_HOLD, CFG_DATA_W'($urandom()));
        random_phase(12, 12, 30);
    endtask

    // The receiver holds off for a long stretch while full runs are requested.
    task automatic test_output_hold_off();
        write_register(CFG_TPR, 16'd360);
        write_register(CFG_HOLD, 16'd99);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_off_len    = 400;
        hold_off_id++;
        send_request(ACT_ACCEPT, 3'd0, 10'sd0, 21'sd40);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_ACCEPT, 3'd1, -10'sd200, 21'sd0);
        send_request(ACT_TRIGGER, 3'd1, 10'sd0, 21'sd0);
        send_request(ACT_CLEAR, 3'd0, 10'sd0, 21'sd0);
        send_request(ACT_TRIGGER, 3'd0, 10'sd0, 21'sd0);
        wait_idle();
    endtask

    // Reset, the test sequence and the final verdict.
    initial
    begin : main_sequence
        int waited;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        test_output_hold_off();
        in_valid <= 1'b0;
        waited = 0;
        while (expected_taps.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_taps.size() != 0)
        begin
            errors++;
            $display("%0t: expected %0d more beats, actual none", $time, expected_taps.size());
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("encoder_rotation_tap_generator: match");
        end
        else
        begin
            $display("encoder_rotation_tap_generator: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/erg_pkg.sv
rtl/erg_divider.sv
rtl/erg_tap_emitter.sv
rtl/encoder_rotation_tap_generator.sv
test/encoder_rotation_tap_generator_tb.sv
